// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/eucl_pkg.sv =====
// types and constants for the euclidean distance block
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package eucl_pkg;

    localparam int SUM_W       = 37;
    localparam int DIST_W      = 18;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
    localparam int ROOT_STEPS  = (SUM_W + 1) / 2;
    localparam int ROOT_X_W    = 2 * ROOT_STEPS;
    localparam int REM_W       = ROOT_STEPS + 3;
    localparam int CNT_W       = $clog2(ROOT_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_ACCL,
        S_ROOT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic square;
        logic accum;
        logic accum_last;
        logic root_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

// ===== hw/rtl/euclidean_distance.sv =====
// top level of the streaming euclidean distance block
// depends on eucl_pkg, eucl_ctrl, eucl_datapath and assert_macros.svh
//
// Each input word carries one coordinate pair of two points in signed Q8.8. A
// word that is not marked last is taken and its difference registered, then
// squared; the add into the 37-bit saturating sum overlaps the next accept. A
// word marked last is followed, before the next word is taken, by square, final
// add, 19 steps of the shared digit-by-digit root unit (two bits of the sum per
// step), the load of the output register and a return to idle. The load waits
// for as long as an earlier distance is still held in the output register. The
// distance, floor of the root in unsigned Q10.8 saturated at 18 bits, then waits
// in the output register while the next vector streams in.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module euclidean_distance
    import eucl_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // coord_a, coord_b
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // distance
    output logic [OUT_TDATA_W-1:0]               m_tdata
);

    cmd_t                cmd;
    status_t             status;
    logic [DIST_W-1:0]   distance;

    eucl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    eucl_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .coord_a  (s_tdata[COORD_WIDTH-1:0]),
        .coord_b  (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .last     (s_tlast),
        .distance (distance)
    );

    assign m_tdata = {{(OUT_TDATA_W - DIST_W){1'b0}}, distance};

    `ASSERT_NEXT(a_square_after_accept, s_tvalid && s_tready, cmd.square,
        "accepted word not squared")
    `ASSERT_SAME(a_no_accept_in_root, cmd.root_step || cmd.accum_last, !s_tready,
        "word accepted during root")
    `ASSERT_NEXT(a_valid_after_load, cmd.out_load, m_tvalid,
        "result loaded but not valid")
    `ASSERT_SAME(a_one_cmd, 1'b1,
        $onehot0({cmd.square, cmd.accum_last, cmd.root_step, cmd.out_load}),
        "conflicting datapath commands")

endmodule

// ===== hw/rtl/eucl_ctrl.sv =====
// controller state machine for the euclidean distance block
// depends on eucl_pkg; drives the datapath through cmd_t
`timescale 1ns / 1ps

module eucl_ctrl
    import eucl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               valid_reg, valid_next;
    logic               accept;
    logic               root_done;

    assign accept    = s_tready && s_tvalid;
    assign root_done = (count_reg == CNT_W'(ROOT_STEPS - 1));
    assign m_tvalid  = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE, S_ACC:
            begin
                if (accept)
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SQ:
            begin
                if (status.last)
                begin
                    state_next = S_ACCL;
                end
                else
                begin
                    state_next = S_ACC;
                end
            end
            S_ACCL:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_ACC:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                cmd.accum   = 1'b1;
            end
            S_SQ:
            begin
                cmd.square = 1'b1;
            end
            S_ACCL:
            begin
                cmd.accum_last = 1'b1;
                count_next     = '0;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                count_next    = count_reg + CNT_W'(1);
            end
            S_OUT:
            begin
                cmd.out_load = !valid_reg || m_tready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hw/rtl/eucl_datapath.sv =====
// datapath: difference, square, saturating sum and digit-by-digit root
// depends on eucl_pkg; commanded by eucl_ctrl
`timescale 1ns / 1ps

module eucl_datapath
    import eucl_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic [COORD_WIDTH-1:0]   coord_a,
    input  logic [COORD_WIDTH-1:0]   coord_b,
    input  logic                     last,
    output logic [DIST_W-1:0]        distance
);

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

    logic signed [COORD_WIDTH:0]   diff;
    logic        [COORD_WIDTH:0]   diff_abs;
    logic        [COORD_WIDTH-1:0] mag_reg;
    logic                          last_reg;
    logic        [SQ_W-1:0]        sq_reg;
    logic        [SUM_W-1:0]       sum_reg, sum_next;
    logic        [ACC_W-1:0]       total;
    logic        [SUM_W-1:0]       sat_sum;
    logic        [ROOT_X_W-1:0]    x_reg;
    logic        [REM_W-1:0]       rem_reg, rem_sh, trial;
    logic        [ROOT_STEPS-1:0]  q_reg;
    logic        [DIST_W-1:0]      dist_reg;

    assign diff     = $signed({coord_a[COORD_WIDTH-1], coord_a})
                    - $signed({coord_b[COORD_WIDTH-1], coord_b});
    assign diff_abs = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;

    assign total   = {{(ACC_W - SUM_W){1'b0}}, sum_reg} + {{(ACC_W - SQ_W){1'b0}}, sq_reg};
    assign sat_sum = (total[ACC_W-1:SUM_W] != '0) ? {SUM_W{1'b1}} : total[SUM_W-1:0];

    assign rem_sh = {rem_reg[REM_W-3:0], x_reg[ROOT_X_W-1 -: 2]};
    assign trial  = {1'b0, q_reg, 2'b01};

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.accum)
        begin
            sum_next = sat_sum;
        end
        else if (cmd.accum_last)
        begin
            sum_next = '0;
        end
    end

    // sum_reg resets to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mag_reg  <= diff_abs[COORD_WIDTH-1:0];
            last_reg <= last;
        end
        if (cmd.square)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
        if (cmd.accum_last)
        begin
            x_reg   <= {{(ROOT_X_W - SUM_W){1'b0}}, sat_sum};
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.root_step)
        begin
            x_reg <= {x_reg[ROOT_X_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                q_reg   <= {q_reg[ROOT_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[ROOT_STEPS-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            dist_reg <= (q_reg[ROOT_STEPS-1:DIST_W] != '0) ? {DIST_W{1'b1}}
                                                         : q_reg[DIST_W-1:0];
        end
    end

    assign status.last = last_reg;
    assign distance    = dist_reg;

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for euclidean_distance, streams coordinate pairs, checks every
// distance word against a typed value or an in-bench squared-sum and floor-root predictor
// depends on eucl_pkg and the euclidean_distance rtl
`timescale 1ns / 1ps

module tb_top
    import eucl_pkg::*;
;

    localparam int COORD_W = 16;
    localparam int IN_W    = ((2 * COORD_W + 7) / 8) * 8;
    localparam logic [SUM_W-1:0]  SUM_TOP  = '1;
    localparam logic [DIST_W-1:0] DIST_TOP = '1;
    localparam int RANDOM_PAIRS = 1600;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        int   a;
        int   b;
        bit   last;
        int   reps;
        bit   known;
        int   dist_val;
    } pair_row_t;

    localparam int N_ROWS = 20;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [SUM_W-1:0]  square_acc = '0;
    logic [DIST_W-1:0] expected_dist[$];
    int                mismatches = 0;
    int                ready_wait = 0;
    bit                no_stall = 1'b0;

    pair_row_t directed_rows[N_ROWS] = '{
        '{0, 0, 1'b1, 1, 1'b1, 0},
        '{32767, -32768, 1'b1, 1, 1'b1, 65535},
        '{-32768, 32767, 1'b1, 1, 1'b1, 65535},
        '{1, 0, 1'b1, 1, 1'b1, 1},
        '{-1, 0, 1'b1, 1, 1'b1, 1},
        '{-32768, -32768, 1'b1, 1, 1'b1, 0},
        '{32767, 32767, 1'b1, 1, 1'b1, 0},
        '{256, -256, 1'b1, 1, 1'b1, 512},
        '{21845, -21846, 1'b1, 1, 1'b1, 43691},
        '{-21846, 21845, 1'b1, 1, 1'b1, 43691},
        '{768, 0, 1'b0, 1, 1'b0, 0},
        '{0, 1024, 1'b1, 1, 1'b1, 1280},
        '{12345, -222, 1'b0, 1, 1'b0, 0},
        '{-7000, 31000, 1'b1, 1, 1'b0, 0},
        '{32767, -32768, 1'b0, 3, 1'b0, 0},
        '{32767, -32768, 1'b1, 1, 1'b1, 131070},
        // distance saturates at 17 full-scale pairs
        '{32767, -32768, 1'b0, 16, 1'b0, 0},
        '{32767, -32768, 1'b1, 1, 1'b1, 262143},
        // sum saturates past 32 full-scale pairs
        '{-32768, 32767, 1'b0, 39, 1'b0, 0},
        '{-32768, 32767, 1'b1, 1, 1'b1, 262143}
    };

    euclidean_distance #(
        .COORD_WIDTH(COORD_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 18; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= 64'(x))
                r = t;
        end
        if (r > 64'(DIST_TOP))
            return DIST_TOP;
        return r[DIST_W-1:0];
    endfunction

    // folds one pair into the running sum, returns 1 when a distance is due
    function automatic bit fold_pair(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                                     input logic last, output logic [DIST_W-1:0] dist_out);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        mag;
        logic [2*COORD_W+1:0]    sq;
        logic [SUM_W:0]          total;
        diff  = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        mag   = diff[COORD_W] ? -diff : diff;
        sq    = (2*COORD_W+2)'(mag) * (2*COORD_W+2)'(mag);
        total = {1'b0, square_acc} + (SUM_W+1)'(sq);
        square_acc = (total > {1'b0, SUM_TOP}) ? SUM_TOP : total[SUM_W-1:0];
        dist_out = '0;
        if (!last)
            return 1'b0;
        dist_out = floor_root(square_acc);
        square_acc = '0;
        return 1'b1;
    endfunction

    task automatic send_pair(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                             input logic last, input int gap,
                             input bit use_typed, input logic [DIST_W-1:0] typed);
        logic [DIST_W-1:0] dist_out;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({b, a});
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (fold_pair(a, b, last, dist_out))
            expected_dist.push_back(use_typed ? typed : dist_out);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_dist.size() != 0);
    endtask

    task automatic note_mismatch(input logic [DIST_W-1:0] want, input logic [DIST_W-1:0] got,
                                 input bit had_word);
        if (mismatches < 10)
        begin
            if (had_word)
                $display("mismatch at %0t: distance expected %0d got %0d", $realtime, want, got);
            else
                $display("mismatch at %0t: unexpected distance word %0d", $realtime, got);
        end
        mismatches++;
    endtask

    function automatic logic [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stall on each offered distance word unless no_stall is set
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            ready_wait = no_stall ? 0 : $urandom_range(0, 3);
            m_tready <= (ready_wait == 0);
        end
        else if (ready_wait > 0)
        begin
            if (m_tvalid)
                ready_wait--;
            m_tready <= (ready_wait == 0);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dist.size() == 0)
                note_mismatch('0, m_tdata[DIST_W-1:0], 1'b0);
            else if (m_tdata[DIST_W-1:0] !== expected_dist[0])
                note_mismatch(expected_dist.pop_front(), m_tdata[DIST_W-1:0], 1'b1);
            else
                void'(expected_dist.pop_front());
        end
    end

    initial
    begin
        #2_000_000;
        $display("** euclidean_distance: FAILED **");
        $finish;
    end

    initial
    begin
        int sent;
        int len;
        int shape;
        bit burst;
        bit paused;
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_pair(16'(directed_rows[i].a), 16'(directed_rows[i].b),
                          directed_rows[i].last, $urandom_range(0, 3),
                          directed_rows[i].known, DIST_W'(directed_rows[i].dist_val));
        end
        wait_results_done();

        sent = 0;
        paused = 1'b0;
        while (sent < RANDOM_PAIRS)
        begin
            shape = $urandom_range(0, 99);
            burst = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 4) == 0);
            if (shape < 65)
                len = $urandom_range(1, 16);
            else if (shape < 80)
                len = $urandom_range(1, 3);
            else if (shape < 92)
                len = $urandom_range(17, 32);
            else
                len = $urandom_range(33, 40);
            for (int k = 0; k < len; k++)
            begin
                if (shape >= 92)
                begin
                    // near full-scale differences to drive the sum into saturation
                    a = 16'h7fff - 16'($urandom_range(0, 255));
                    b = 16'h8000 + 16'($urandom_range(0, 255));
                    if ($urandom_range(0, 1))
                        {a, b} = {b, a};
                end
                else if (shape >= 65 && shape < 80)
                begin
                    a = edge_coord();
                    b = edge_coord();
                end
                else
                begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
                send_pair(a, b, k == len - 1, burst ? 0 : $urandom_range(0, 3), 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= RANDOM_PAIRS / 2)
            begin
                wait_results_done();
                paused = 1'b1;
            end
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_dist.size() == 0)
            $display("** euclidean_distance: PASSED **");
        else
            $display("** euclidean_distance: FAILED **");
        $finish;
    end

endmodule

// ===== euclidean_distance.f =====
+incdir+hw/rtl
hw/rtl/eucl_pkg.sv
hw/rtl/eucl_ctrl.sv
hw/rtl/eucl_datapath.sv
hw/rtl/euclidean_distance.sv
test/tb_top.sv
